// File: hw/rtl/lred_pkg.sv
// Shared constants, register indexes and result type for the local range edge detector.
// No dependencies.
package lred_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int COL_W = $clog2(MAX_WIDTH);       // column inside a row
  localparam int DW    = $clog2(MAX_WIDTH + 2);   // width, lead, ring slot (up to width+1)
  localparam int ROW_W = $clog2(MAX_HEIGHT);      // output row
  localparam int DH    = $clog2(MAX_HEIGHT + 1);  // height, input row (up to height)

  localparam int RING_DEPTH = MAX_WIDTH + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd25;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;

  // gray = floor((33b + 56g + 11r) / 100), divide by reciprocal 5243 / 2^19
  localparam int WSUM_W     = 15;
  localparam int W_BLUE     = 33;
  localparam int W_GREEN    = 56;
  localparam int W_RED      = 11;
  localparam int GRAY_MUL   = 5243;
  localparam int GRAY_MUL_W = 13;
  localparam int GRAY_SHIFT = 19;

  localparam logic [PIX_W-1:0] PIX_EDGE = 8'd0;
  localparam logic [PIX_W-1:0] PIX_FLAT = 8'd255;

  localparam int OUT_DEPTH = 4;
  localparam int QPTR_W    = $clog2(OUT_DEPTH);
  localparam int QCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_last;
  } lred_result_t;

endpackage

// File: hw/rtl/lred_ram.sv
// Generic single-write, single-read synchronous RAM with registered read (read-first).
// No dependencies.
module lred_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        write_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
  input  logic [WIDTH-1:0]                            write_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
  output logic [WIDTH-1:0]                            read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
    read_data <= mem[read_addr];
  end

endmodule

// File: hw/rtl/lred_out_fifo.sv
// Small output queue of result transactions; registers only.
// Depends on lred_pkg.
module lred_out_fifo import lred_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lred_result_t      push_data,
  input  logic              pop_ready,
  output logic              pop_valid,
  output lred_result_t      pop_data,
  output logic [QCNT_W-1:0] count
);

  lred_result_t      mem [OUT_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/local_range_edge_detector.sv
// Local range edge detector: 3x3 blue range threshold, gray border, raster order stream.
// Depends on lred_pkg, lred_ram, lred_out_fifo.
// Throughput: one transaction per cycle while in_ready is high (output queue has room); the
// line RAM (both row parities in one word) and the gray ring RAM each take one read and one
// write a cycle. A result passes RAM read, window update and range compare before the queue.
// Reset: synchronous; clears positions, window, queue and registers; RAMs are not cleared.
module local_range_edge_detector import lred_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      blue,
  input  logic [PIX_W-1:0]      green,
  input  logic [PIX_W-1:0]      red,
  input  logic                  flush,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_value,
  output logic                  frame_last
);

  function automatic logic [DW-1:0] clamp_w(logic [FW_W-1:0] v);
    if (32'(v) < MIN_DIM) return DW'(MIN_DIM);
    else if (32'(v) > MAX_WIDTH) return DW'(MAX_WIDTH);
    else return DW'(v);
  endfunction

  function automatic logic [DH-1:0] clamp_h(logic [FH_W-1:0] v);
    if (32'(v) < MIN_DIM) return DH'(MIN_DIM);
    else if (32'(v) > MAX_HEIGHT) return DH'(MAX_HEIGHT);
    else return DH'(v);
  endfunction

  // configuration
  logic [THR_W-1:0] threshold;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;

  // frame position state
  logic [DH-1:0]    input_row, input_row_next;
  logic [COL_W-1:0] input_column, input_column_next;
  logic [ROW_W-1:0] output_row, output_row_next;
  logic [COL_W-1:0] output_column, output_column_next;
  logic [DW-1:0]    lead, lead_next;
  logic [DW-1:0]    gray_slot, gray_slot_next;
  logic [DW-1:0]    cur_w, cur_w_next;
  logic [DH-1:0]    cur_h, cur_h_next;

  logic             accept, start, in_done, active, emit, wr_pix;
  logic [DW-1:0]    eff_w;
  logic [DH-1:0]    eff_h;
  logic             interior, last;
  logic [WSUM_W-1:0] wsum;

  // pipeline stage 1 (RAM read data valid)
  logic              p1_emit, p1_win, p1_par, p1_interior, p1_last;
  logic [PIX_W-1:0]  p1_b;
  logic [COL_W-1:0]  p1_col;
  logic [RING_AW-1:0] p1_slot;
  logic [WSUM_W-1:0] p1_wsum;

  // pipeline stage 2 (window updated)
  logic              p2_emit, p2_interior, p2_last;
  logic [PIX_W-1:0]  p2_gray_old;

  logic [PIX_W-1:0] blue_window [9];

  logic [2*PIX_W-1:0] line_rd, line_wdata;
  logic [PIX_W-1:0] ring_rd, here_rd, prev_rd;
  logic [GRAY_MUL_W+WSUM_W-1:0] gray_prod;
  logic [PIX_W-1:0] gray;

  lred_result_t      result;
  lred_result_t      q_data;
  logic [QCNT_W-1:0] q_count;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data[THR_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  assign in_ready = (QCNT_W'(q_count) + QCNT_W'(p1_emit) + QCNT_W'(p2_emit))
                    < QCNT_W'(OUT_DEPTH);
  assign accept   = in_valid && in_ready;

  assign start   = (lead == '0) && (input_row == '0) && (input_column == '0);
  assign eff_w   = start ? clamp_w(frame_width) : cur_w;
  assign eff_h   = start ? clamp_h(frame_height) : cur_h;
  assign in_done = (input_row >= eff_h);
  assign active  = accept && (in_done || !flush);
  assign emit    = (lead == eff_w + DW'(1));
  assign wr_pix  = active && !in_done;

  assign interior = (output_row != '0)
                 && ((DH+1)'(output_row) + (DH+1)'(2) <= (DH+1)'(eff_h))
                 && (output_column != '0)
                 && ((DW+1)'(output_column) + (DW+1)'(2) <= (DW+1)'(eff_w));
  assign last = ((DH+1)'(output_row) + (DH+1)'(1) == (DH+1)'(eff_h))
             && ((DW+1)'(output_column) + (DW+1)'(1) == (DW+1)'(eff_w));

  assign wsum = WSUM_W'(blue)  * WSUM_W'(W_BLUE)
              + WSUM_W'(green) * WSUM_W'(W_GREEN)
              + WSUM_W'(red)   * WSUM_W'(W_RED);

  always_comb begin
    input_row_next     = input_row;
    input_column_next  = input_column;
    output_row_next    = output_row;
    output_column_next = output_column;
    lead_next          = lead;
    gray_slot_next     = gray_slot;
    cur_w_next         = cur_w;
    cur_h_next         = cur_h;
    if (accept) begin
      cur_w_next = eff_w;
      cur_h_next = eff_h;
    end
    if (active) begin
      if (!in_done) begin
        if (DW'(input_column) + DW'(1) >= eff_w) begin
          input_column_next = '0;
          input_row_next    = input_row + DH'(1);
        end else begin
          input_column_next = input_column + COL_W'(1);
        end
      end
      gray_slot_next = (gray_slot >= eff_w) ? '0 : gray_slot + DW'(1);
      if (!emit) begin
        lead_next = lead + DW'(1);
      end else if (last) begin
        input_row_next     = '0;
        input_column_next  = '0;
        output_row_next    = '0;
        output_column_next = '0;
        lead_next          = '0;
        gray_slot_next     = '0;
      end else if (DW'(output_column) + DW'(1) >= eff_w) begin
        output_column_next = '0;
        output_row_next    = output_row + ROW_W'(1);
      end else begin
        output_column_next = output_column + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_row     <= '0;
      input_column  <= '0;
      output_row    <= '0;
      output_column <= '0;
      lead          <= '0;
      gray_slot     <= '0;
      cur_w         <= clamp_w(FRAME_WIDTH_RST);
      cur_h         <= clamp_h(FRAME_HEIGHT_RST);
    end else begin
      input_row     <= input_row_next;
      input_column  <= input_column_next;
      output_row    <= output_row_next;
      output_column <= output_column_next;
      lead          <= lead_next;
      gray_slot     <= gray_slot_next;
      cur_w         <= cur_w_next;
      cur_h         <= cur_h_next;
    end
  end

  // line store: even row in the low byte, odd row in the high byte; ring of gray values
  lred_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk        (clk),
    .write_en   (p1_win),
    .write_addr (p1_col),
    .write_data (line_wdata),
    .read_addr  (input_column),
    .read_data  (line_rd)
  );

  lred_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk        (clk),
    .write_en   (p1_win),
    .write_addr (p1_slot),
    .write_data (gray),
    .read_addr  (gray_slot[RING_AW-1:0]),
    .read_data  (ring_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_emit <= 1'b0;
      p1_win  <= 1'b0;
    end else begin
      p1_emit <= active && emit;
      p1_win  <= wr_pix;
    end
  end

  always_ff @(posedge clk) begin
    p1_par      <= input_row[0];
    p1_b        <= blue;
    p1_col      <= input_column;
    p1_interior <= interior;
    p1_last     <= last;
    p1_slot     <= gray_slot[RING_AW-1:0];
    p1_wsum     <= wsum;
  end

  // ---------------------------------------------------------------- stage 1
  assign here_rd    = p1_par ? line_rd[PIX_W +: PIX_W] : line_rd[0 +: PIX_W];
  assign prev_rd    = p1_par ? line_rd[0 +: PIX_W] : line_rd[PIX_W +: PIX_W];
  assign line_wdata = p1_par ? {p1_b, prev_rd} : {prev_rd, p1_b};
  assign gray_prod = (GRAY_MUL_W+WSUM_W)'(p1_wsum) * (GRAY_MUL_W+WSUM_W)'(GRAY_MUL);
  assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        blue_window[k] <= '0;
      end
    end else if (p1_win) begin
      for (int k = 0; k < 3; k++) begin
        blue_window[k*3]     <= blue_window[k*3 + 1];
        blue_window[k*3 + 1] <= blue_window[k*3 + 2];
      end
      blue_window[2] <= here_rd;
      blue_window[5] <= prev_rd;
      blue_window[8] <= p1_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_emit <= 1'b0;
    end else begin
      p2_emit <= p1_emit;
    end
  end

  always_ff @(posedge clk) begin
    p2_interior <= p1_interior;
    p2_last     <= p1_last;
    p2_gray_old <= ring_rd;
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    mx = blue_window[0];
    mn = blue_window[0];
    for (int k = 1; k < 9; k++) begin
      if (blue_window[k] > mx) mx = blue_window[k];
      if (blue_window[k] < mn) mn = blue_window[k];
    end
    if (p2_interior) begin
      result.pixel_value = ((mx - mn) > threshold) ? PIX_EDGE : PIX_FLAT;
    end else begin
      result.pixel_value = p2_gray_old;
    end
    result.frame_last = p2_last;
  end

  lred_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p2_emit),
    .push_data (result),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  assign pixel_value = q_data.pixel_value;
  assign frame_last  = q_data.frame_last;

endmodule
